>>> hw/rtl/decimal_text_to_reduced_fraction_unit_macros.svh
// Assertion macros used by the checker file of the decimal text converter.
`ifndef DECIMAL_TEXT_TO_REDUCED_FRACTION_UNIT_MACROS_SVH
`define DECIMAL_TEXT_TO_REDUCED_FRACTION_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define DTRF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is low.
`define DTRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define DTRF_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/dtrf_pkg.sv
// Package with widths, character codes and helpers of the decimal text converter.
package dtrf_pkg;

    localparam int MAX_DIGITS_DEF = 7;
    localparam int OUT_W          = 24;
    localparam int CHAR_W         = 8;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_POINT   = 8'd46;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;

    // x / 5 == (x * RECIP5) >> RECIP5_SHIFT for every x below 2^32
    localparam int          RECIP5_W     = 32;
    localparam int          RECIP5_SHIFT = 34;
    localparam logic [31:0] RECIP5       = 32'hCCCC_CCCD;

    function automatic int acc_width(input int digits);
        longint p;
        p = 1;
        for (int i = 0; i < digits; i++) begin
            p = p * 10;
        end
        return $clog2(p + 1);
    endfunction

endpackage

>>> hw/rtl/decimal_text_to_reduced_fraction_unit.sv
// Top level of the decimal text to reduced fraction converter.
//
//  channel | direction | payload                                          | handshake
//  s_      | in        | char_code[7:0]                                   | s_valid / s_ready
//  m_      | out       | whole_part, numerator, denominator [23:0], too_long | m_valid / m_ready
//
//  Digits, points and other bytes are taken in the idle state and keep s_ready high.
//  A newline runs the reduction sequencer: up to D halving steps, up to D
//  divide-by-five tests (reciprocal multiply, then check, in separate states),
//  and up to 2*D shift-add steps to rebuild the denominator (D = fraction digits).
//  s_ready stays low from the newline until the result is loaded, including any wait for m_ready.
//  The result sits in an output register; a stalled m_ready delays only the load.
//  Reset (aresetn low, synchronous) clears the accumulators and the output valid.
module decimal_text_to_reduced_fraction_unit
    import dtrf_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_char_code,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [OUT_W-1:0]  m_whole_part,
    output logic [OUT_W-1:0]  m_numerator,
    output logic [OUT_W-1:0]  m_denominator,
    output logic              m_too_long
);

    localparam int ACC_W  = acc_width(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int PROD_W = ACC_W + RECIP5_W;

    localparam logic [CNT_W-1:0] DIGIT_LIMIT = CNT_W'(MAX_DIGITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TWO,
        ST_FIVE_MUL,
        ST_FIVE_CHK,
        ST_DEN,
        ST_LOAD
    } state_t;

    state_t             state_reg, state_next;
    logic [ACC_W-1:0]   whole_acc_reg, whole_acc_next;
    logic [ACC_W-1:0]   frac_acc_reg, frac_acc_next;
    logic [CNT_W-1:0]   whole_digits_reg, whole_digits_next;
    logic [CNT_W-1:0]   frac_digits_reg, frac_digits_next;
    logic               after_point_reg, after_point_next;
    logic               overflow_reg, overflow_next;
    logic [ACC_W-1:0]   num_reg, num_next;
    logic [ACC_W-1:0]   den_reg, den_next;
    logic [CNT_W-1:0]   exp2_reg, exp2_next;
    logic [CNT_W-1:0]   exp5_reg, exp5_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]   whole_out_reg, whole_out_next;
    logic [OUT_W-1:0]   num_out_reg, num_out_next;
    logic [OUT_W-1:0]   den_out_reg, den_out_next;
    logic               too_long_reg, too_long_next;

    logic [ACC_W-1:0]   digit_val;
    logic [ACC_W-1:0]   acc_in;
    logic [ACC_W-1:0]   acc_times_ten;
    logic [ACC_W-1:0]   quot;
    logic [ACC_W-1:0]   quot_times_five;
    logic               s_fire;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign m_valid       = m_valid_reg;
    assign m_whole_part  = whole_out_reg;
    assign m_numerator   = num_out_reg;
    assign m_denominator = den_out_reg;
    assign m_too_long    = too_long_reg;

    assign digit_val       = ACC_W'(s_char_code - CH_ZERO);
    assign acc_in          = after_point_reg ? frac_acc_reg : whole_acc_reg;
    assign acc_times_ten   = (acc_in << 3) + (acc_in << 1) + digit_val;
    assign quot            = ACC_W'(prod_reg[PROD_W-1:RECIP5_SHIFT]);
    assign quot_times_five = (quot << 2) + quot;

    always_comb begin
        state_next        = state_reg;
        whole_acc_next    = whole_acc_reg;
        frac_acc_next     = frac_acc_reg;
        whole_digits_next = whole_digits_reg;
        frac_digits_next  = frac_digits_reg;
        after_point_next  = after_point_reg;
        overflow_next     = overflow_reg;
        num_next          = num_reg;
        den_next          = den_reg;
        exp2_next         = exp2_reg;
        exp5_next         = exp5_reg;
        prod_next         = prod_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        whole_out_next    = whole_out_reg;
        num_out_next      = num_out_reg;
        den_out_next      = den_out_reg;
        too_long_next     = too_long_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_char_code inside {[CH_ZERO:CH_NINE]}) begin
                        if (after_point_reg) begin
                            if (frac_digits_reg >= DIGIT_LIMIT) begin
                                overflow_next = 1'b1;
                            end else begin
                                frac_acc_next    = acc_times_ten;
                                frac_digits_next = frac_digits_reg + 1'b1;
                            end
                        end else begin
                            if (whole_digits_reg >= DIGIT_LIMIT) begin
                                overflow_next = 1'b1;
                            end else begin
                                whole_acc_next    = acc_times_ten;
                                whole_digits_next = whole_digits_reg + 1'b1;
                            end
                        end
                    end else if (s_char_code == CH_POINT) begin
                        after_point_next = 1'b1;
                    end else if (s_char_code == CH_NEWLINE) begin
                        num_next   = frac_acc_reg;
                        den_next   = ACC_W'(1);
                        exp2_next  = (frac_acc_reg == '0) ? '0 : frac_digits_reg;
                        exp5_next  = (frac_acc_reg == '0) ? '0 : frac_digits_reg;
                        state_next = ST_TWO;
                    end
                end
            end
            ST_TWO: begin
                if (exp2_reg != '0 && !num_reg[0]) begin
                    num_next  = num_reg >> 1;
                    exp2_next = exp2_reg - 1'b1;
                end else begin
                    state_next = ST_FIVE_MUL;
                end
            end
            ST_FIVE_MUL: begin
                if (exp5_reg == '0) begin
                    state_next = ST_DEN;
                end else begin
                    prod_next  = PROD_W'(num_reg) * PROD_W'(RECIP5);
                    state_next = ST_FIVE_CHK;
                end
            end
            ST_FIVE_CHK: begin
                if (quot_times_five == num_reg) begin
                    num_next   = quot;
                    exp5_next  = exp5_reg - 1'b1;
                    state_next = ST_FIVE_MUL;
                end else begin
                    state_next = ST_DEN;
                end
            end
            ST_DEN: begin
                if (exp2_reg != '0) begin
                    den_next  = den_reg << 1;
                    exp2_next = exp2_reg - 1'b1;
                end else if (exp5_reg != '0) begin
                    den_next  = (den_reg << 2) + den_reg;
                    exp5_next = exp5_reg - 1'b1;
                end else begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    whole_out_next    = OUT_W'(whole_acc_reg);
                    num_out_next      = OUT_W'(num_reg);
                    den_out_next      = OUT_W'(den_reg);
                    too_long_next     = overflow_reg;
                    whole_acc_next    = '0;
                    frac_acc_next     = '0;
                    whole_digits_next = '0;
                    frac_digits_next  = '0;
                    after_point_next  = 1'b0;
                    overflow_next     = 1'b0;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            whole_acc_reg    <= '0;
            frac_acc_reg     <= '0;
            whole_digits_reg <= '0;
            frac_digits_reg  <= '0;
            after_point_reg  <= 1'b0;
            overflow_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            whole_acc_reg    <= whole_acc_next;
            frac_acc_reg     <= frac_acc_next;
            whole_digits_reg <= whole_digits_next;
            frac_digits_reg  <= frac_digits_next;
            after_point_reg  <= after_point_next;
            overflow_reg     <= overflow_next;
            m_valid_reg      <= m_valid_next;
        end
        num_reg       <= num_next;
        den_reg       <= den_next;
        exp2_reg      <= exp2_next;
        exp5_reg      <= exp5_next;
        prod_reg      <= prod_next;
        whole_out_reg <= whole_out_next;
        num_out_reg   <= num_out_next;
        den_out_reg   <= den_out_next;
        too_long_reg  <= too_long_next;
    end

endmodule

>>> hw/rtl/dtrf_checker.sv
// Port-level checker of the decimal text converter, bound to the top level.
`include "decimal_text_to_reduced_fraction_unit_macros.svh"

module dtrf_checker
    import dtrf_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [CHAR_W-1:0] s_char_code,
    input logic              m_valid,
    input logic              m_ready,
    input logic [OUT_W-1:0]  m_whole_part,
    input logic [OUT_W-1:0]  m_numerator,
    input logic [OUT_W-1:0]  m_denominator,
    input logic              m_too_long
);

    logic [3*OUT_W:0] m_payload;
    logic             s_newline_fire;

    assign m_payload      = {m_whole_part, m_numerator, m_denominator, m_too_long};
    assign s_newline_fire = s_valid && s_ready && (s_char_code == CH_NEWLINE);

    `DTRF_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))
    `DTRF_ASSERT_NEXT(a_newline_stalls, aclk, aresetn, s_newline_fire, !s_ready && !$rose(m_valid))
    `DTRF_ASSERT_IMPL(a_den_nonzero, aclk, aresetn, m_valid, m_denominator != '0)
    `DTRF_ASSERT_NEXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_valid && s_ready)

endmodule

bind decimal_text_to_reduced_fraction_unit dtrf_checker u_dtrf_checker (.*);

>>> bench/dtrf_fraction_check_pkg.sv
// Scoreboard class that predicts and checks reduced fractions from the character stream.
package dtrf_fraction_check_pkg;
    import dtrf_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] whole_part;
        logic [OUT_W-1:0] numerator;
        logic [OUT_W-1:0] denominator;
        logic             too_long;
    } fraction_t;

    class fraction_scoreboard;
        int unsigned whole_acc;
        int unsigned frac_acc;
        int unsigned whole_digits;
        int unsigned frac_digits;
        bit          after_point;
        bit          overflow_seen;
        fraction_t   expected_fractions[$];
        int          mismatches;

        function new();
            clear_number();
            mismatches = 0;
        endfunction

        function void clear_number();
            whole_acc     = 0;
            frac_acc      = 0;
            whole_digits  = 0;
            frac_digits   = 0;
            after_point   = 1'b0;
            overflow_seen = 1'b0;
        endfunction

        function int outstanding();
            return expected_fractions.size();
        endfunction

        function void note_char(logic [CHAR_W-1:0] c);
            int unsigned d;
            int unsigned num;
            int unsigned den;
            fraction_t   f;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
                if (after_point) begin
                    if (frac_digits >= MAX_DIGITS_DEF) begin
                        overflow_seen = 1'b1;
                    end else begin
                        frac_acc    = frac_acc * 10 + d;
                        frac_digits = frac_digits + 1;
                    end
                end else begin
                    if (whole_digits >= MAX_DIGITS_DEF) begin
                        overflow_seen = 1'b1;
                    end else begin
                        whole_acc    = whole_acc * 10 + d;
                        whole_digits = whole_digits + 1;
                    end
                end
            end else if (c == CH_POINT) begin
                after_point = 1'b1;
            end else if (c == CH_NEWLINE) begin
                num = frac_acc;
                den = 1;
                for (int k = 0; k < frac_digits; k++) begin
                    den = den * 10;
                end
                if (num == 0) begin
                    den = 1;
                end else begin
                    while (num % 2 == 0 && den % 2 == 0) begin
                        num = num / 2;
                        den = den / 2;
                    end
                    while (num % 5 == 0 && den % 5 == 0) begin
                        num = num / 5;
                        den = den / 5;
                    end
                end
                f.whole_part  = whole_acc[OUT_W-1:0];
                f.numerator   = num[OUT_W-1:0];
                f.denominator = den[OUT_W-1:0];
                f.too_long    = overflow_seen;
                expected_fractions.push_back(f);
                clear_number();
            end
        endfunction

        function void check_result(fraction_t got);
            fraction_t exp_f;
            if (expected_fractions.size() == 0) begin
                $error("unexpected result: whole %0d num %0d den %0d too_long %0b",
                       got.whole_part, got.numerator, got.denominator, got.too_long);
                mismatches++;
                return;
            end
            exp_f = expected_fractions.pop_front();
            if (got.whole_part !== exp_f.whole_part) begin
                $error("whole_part: expected %0d, actual %0d", exp_f.whole_part,
                       got.whole_part);
                mismatches++;
            end
            if (got.numerator !== exp_f.numerator) begin
                $error("numerator: expected %0d, actual %0d", exp_f.numerator,
                       got.numerator);
                mismatches++;
            end
            if (got.denominator !== exp_f.denominator) begin
                $error("denominator: expected %0d, actual %0d", exp_f.denominator,
                       got.denominator);
                mismatches++;
            end
            if (got.too_long !== exp_f.too_long) begin
                $error("too_long: expected %0b, actual %0b", exp_f.too_long, got.too_long);
                mismatches++;
            end
        endfunction
    endclass

endpackage

>>> bench/tb_decimal_text_to_reduced_fraction_unit.sv
// Testbench driving character streams into the converter and checking every fraction.
module tb_decimal_text_to_reduced_fraction_unit;
    import dtrf_pkg::*;
    import dtrf_fraction_check_pkg::*;

    localparam int TARGET_CHARS = 1050;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [CHAR_W-1:0] s_char_code;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [OUT_W-1:0]  m_whole_part;
    logic [OUT_W-1:0]  m_numerator;
    logic [OUT_W-1:0]  m_denominator;
    logic              m_too_long;

    fraction_scoreboard sb = new();

    int burst_left = 0;
    int chars_sent = 0;
    int stall_mode = 0;
    int stall_left = 0;

    decimal_text_to_reduced_fraction_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_whole_part  (m_whole_part),
        .m_numerator   (m_numerator),
        .m_denominator (m_denominator),
        .m_too_long    (m_too_long)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver stall pattern: switch between always ready, coin flip and long stalls.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(40, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        fraction_t got;
        if (aresetn && m_valid && m_ready) begin
            got.whole_part  = m_whole_part;
            got.numerator   = m_numerator;
            got.denominator = m_denominator;
            got.too_long    = m_too_long;
            sb.check_result(got);
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] c);
        s_valid     <= 1'b1;
        s_char_code <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_char(c);
        chars_sent++;
    endtask

    task automatic idle_gap(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Send in bursts; now and then a long burst with no idling.
    task automatic emit(input logic [CHAR_W-1:0] c);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) begin
                idle_gap($urandom_range(1, 8));
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        send_char(c);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    function automatic logic [CHAR_W-1:0] rand_digit();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return CH_ZERO;
        if (r == 3) return CH_ZERO + 8'd5;
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic maybe_noise();
        if ($urandom_range(0, 24) == 0) begin
            emit(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic emit_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            emit(s[i]);
        end
    endtask

    task automatic send_number();
        int nw;
        int nf;
        nw = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 7);
        nf = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 7);
        for (int i = 0; i < nw; i++) begin
            emit(rand_digit());
            maybe_noise();
        end
        if ($urandom_range(0, 7) != 0) begin
            emit(CH_POINT);
            if ($urandom_range(0, 15) == 0) emit(CH_POINT);
            for (int i = 0; i < nf; i++) begin
                emit(rand_digit());
                maybe_noise();
            end
        end
        emit(CH_NEWLINE);
    endtask

    task automatic send_garbage();
        int n;
        int r;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 3);
            case (r)
                0: emit(CH_POINT);
                1: emit(8'($urandom_range(0, 255)));
                default: emit(rand_digit());
            endcase
        end
        if ($urandom_range(0, 1) == 0) emit(CH_NEWLINE);
    endtask

    initial begin
        int drained_mid;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_char_code = '0;
        drained_mid = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes of the byte, empty line, whole overflow with repeated point,
        // fraction overflow with an all-zero fraction.
        emit(8'h00);
        emit(8'hFF);
        emit(CH_NEWLINE);
        emit_text("99999999..5\n");
        emit_text("0.00000000\n");
        drain();

        while (chars_sent < TARGET_CHARS) begin
            if ($urandom_range(0, 9) == 0) send_garbage();
            else send_number();
            if (!drained_mid && chars_sent > TARGET_CHARS / 2) begin
                drain();
                drained_mid = 1;
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
